>>> rtl/core/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// hrhp_pkg
// Shared types, character codes and limits of the request head parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  // longest request head taken before it is declared bad
  localparam int unsigned MaxHeadBytes = 4096;
  // byte counter must be able to hold MaxHeadBytes itself
  localparam int unsigned OffW         = $clog2(MaxHeadBytes + 1);
  // offsets and lengths on the result wrap at this width
  localparam int unsigned FieldW       = 12;
  localparam int unsigned CountW       = 8;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChQmark = 8'h3f;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpH   = 8'h48;
  localparam logic [7:0] ChUpP   = 8'h50;
  localparam logic [7:0] ChUpT   = 8'h54;
  localparam logic [7:0] ChUpZ   = 8'h5a;

  localparam logic [31:0] MethodGet  = 32'h0047_4554;
  localparam logic [31:0] MethodPost = 32'h504f_5354;

  typedef enum logic [3:0] {
    ST_MORE       = 4'd0,
    ST_LINE_DONE  = 4'd1,
    ST_HDR_DONE   = 4'd2,
    ST_HEAD_DONE  = 4'd3,
    ST_BAD_METHOD = 4'd4,
    ST_BAD_REQ    = 4'd5,
    ST_BAD_URI    = 4'd6,
    ST_BAD_VER    = 4'd7,
    ST_BAD_HDR    = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    MK_NONE  = 2'd0,
    MK_GET   = 2'd1,
    MK_POST  = 2'd2,
    MK_OTHER = 2'd3
  } method_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
  } hrhp_in_t;

  typedef struct packed {
    status_e               status;
    method_e               method_kind;
    logic [FieldW-1:0]     uri_start;
    logic [FieldW-1:0]     uri_len;
    logic [FieldW-1:0]     query_start;
    logic [FieldW-1:0]     query_len;
    logic                  minor_version;
    logic [FieldW-1:0]     name_start;
    logic [FieldW-1:0]     name_len;
    logic [FieldW-1:0]     value_start;
    logic [FieldW-1:0]     value_len;
    logic [CountW-1:0]     header_count;
  } hrhp_result_t;

  function automatic logic is_error(status_e s);
    return (s == ST_BAD_METHOD) || (s == ST_BAD_REQ) || (s == ST_BAD_URI) ||
           (s == ST_BAD_VER) || (s == ST_BAD_HDR);
  endfunction

  // expected text "HTTP/1." ahead of the minor digit
  function automatic logic [7:0] ver_char(logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = ChUpH;
      3'd1:    ch = ChUpT;
      3'd2:    ch = ChUpT;
      3'd3:    ch = ChUpP;
      3'd4:    ch = ChSlash;
      3'd5:    ch = ChOne;
      3'd6:    ch = ChDot;
      default: ch = ChNul;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/core/hrhp_byte_if.sv
// ----------------------------------------------------------------------------
// hrhp_byte_if
// Byte request channel into the parser: valid, ready and one data byte.
// ----------------------------------------------------------------------------
interface hrhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

>>> rtl/core/hrhp_result_if.sv
// ----------------------------------------------------------------------------
// hrhp_result_if
// Result channel of the parser: one status word with offsets per byte.
// ----------------------------------------------------------------------------
interface hrhp_result_if;
  logic                                valid;
  logic                                ready;
  hrhp_pkg::status_e                   status;
  hrhp_pkg::method_e                   method_kind;
  logic [hrhp_pkg::FieldW-1:0]         uri_start;
  logic [hrhp_pkg::FieldW-1:0]         uri_len;
  logic [hrhp_pkg::FieldW-1:0]         query_start;
  logic [hrhp_pkg::FieldW-1:0]         query_len;
  logic                                minor_version;
  logic [hrhp_pkg::FieldW-1:0]         name_start;
  logic [hrhp_pkg::FieldW-1:0]         name_len;
  logic [hrhp_pkg::FieldW-1:0]         value_start;
  logic [hrhp_pkg::FieldW-1:0]         value_len;
  logic [hrhp_pkg::CountW-1:0]         header_count;

  modport source (
    output valid, output status, output method_kind, output uri_start,
    output uri_len, output query_start, output query_len, output minor_version,
    output name_start, output name_len, output value_start, output value_len,
    output header_count, input ready
  );
  modport sink (
    input valid, input status, input method_kind, input uri_start,
    input uri_len, input query_start, input query_len, input minor_version,
    input name_start, input name_len, input value_start, input value_len,
    input header_count, output ready
  );
endinterface

>>> rtl/core/hrhp_in_reg.sv
// ----------------------------------------------------------------------------
// hrhp_in_reg
// Input register: holds one byte request until the parser takes it.
// ----------------------------------------------------------------------------
module hrhp_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  hrhp_byte_if.sink          req_i,
  input  logic               take_i,
  output hrhp_pkg::hrhp_in_t in_o
);
  import hrhp_pkg::*;

  logic       valid_q;
  logic [7:0] data_q;

  // refill in the same cycle the held byte moves on
  assign req_i.ready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      data_q <= req_i.data_byte;
    end
  end

  assign in_o.valid     = valid_q;
  assign in_o.data_byte = data_q;

endmodule

>>> rtl/core/hrhp_parser.sv
// ----------------------------------------------------------------------------
// hrhp_parser
// Request line and header state machine; one byte per fire, result comb.
// ----------------------------------------------------------------------------
module hrhp_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  logic [7:0]             data_byte_i,
  output hrhp_pkg::hrhp_result_t res_o
);
  import hrhp_pkg::*;

  typedef enum logic [4:0] {
    P_START,
    P_METHOD,
    P_SP_URI,
    P_URI,
    P_QMARK,
    P_QUERY,
    P_VER,
    P_VMINOR,
    P_VCR,
    P_VLF,
    H_START,
    H_NAME,
    H_COLON,
    H_SP_VAL,
    H_VALUE,
    H_SP_AFTER,
    H_LF,
    H_END_LF
  } state_e;

  typedef struct packed {
    state_e            state;
    logic [2:0]        ver_idx;
    logic [OffW-1:0]   offset;
    logic [31:0]       method_chars;
    logic [2:0]        method_len;
    method_e           method_code;
    logic [FieldW-1:0] uri_begin;
    logic [FieldW-1:0] uri_length;
    logic [FieldW-1:0] query_begin;
    logic [FieldW-1:0] query_length;
    logic              ver_minor;
    logic [FieldW-1:0] name_begin;
    logic [FieldW-1:0] name_length;
    logic [FieldW-1:0] value_begin;
    logic [FieldW-1:0] value_length;
    logic [CountW-1:0] headers_seen;
  } ctx_t;

  ctx_t              ctx_q, ctx_d, adv;
  status_e           err_q, err_d;
  status_e           status;
  logic [7:0]        c;
  logic [FieldW-1:0] pos;
  logic              upper;

  assign c     = data_byte_i;
  assign pos   = FieldW'(ctx_q.offset);
  assign upper = (c >= ChUpA) && (c <= ChUpZ);

  always_comb begin
    adv    = ctx_q;
    status = ST_MORE;
    if (err_q != ST_MORE) begin
      status = err_q;
    end else if (ctx_q.offset >= OffW'(MaxHeadBytes)) begin
      status = ST_BAD_REQ;
    end else begin
      case (ctx_q.state)
        P_START: begin
          // leading line breaks are skipped
          if (c == ChCr || c == ChLf) begin
            adv.state = P_START;
          end else if (!upper) begin
            status = ST_BAD_METHOD;
          end else begin
            adv.method_chars = {24'h0, c};
            adv.method_len   = 3'd1;
            adv.state        = P_METHOD;
          end
        end
        P_METHOD: begin
          if (c == ChSpace) begin
            if (ctx_q.method_len == 3'd3) begin
              if (ctx_q.method_chars != MethodGet) begin
                status = ST_BAD_METHOD;
              end else begin
                adv.method_code = MK_GET;
                adv.state       = P_SP_URI;
              end
            end else if (ctx_q.method_len == 3'd4) begin
              if (ctx_q.method_chars != MethodPost) begin
                status = ST_BAD_METHOD;
              end else begin
                adv.method_code = MK_POST;
                adv.state       = P_SP_URI;
              end
            end else begin
              adv.method_code = MK_OTHER;
              adv.state       = P_SP_URI;
            end
          end else if (!upper) begin
            status = ST_BAD_METHOD;
          end else begin
            if (ctx_q.method_len < 3'd4) begin
              adv.method_chars = {ctx_q.method_chars[23:0], c};
            end
            if (ctx_q.method_len < 3'd7) begin
              adv.method_len = ctx_q.method_len + 3'd1;
            end
          end
        end
        P_SP_URI: begin
          if (c != ChSlash) begin
            status = ST_BAD_REQ;
          end else begin
            adv.uri_begin = pos;
            adv.state     = P_URI;
          end
        end
        P_URI: begin
          if (c == ChNul) begin
            status = ST_BAD_URI;
          end else if (c == ChSpace || c == ChQmark) begin
            adv.uri_length = pos - ctx_q.uri_begin;
            adv.state      = (c == ChSpace) ? P_VER : P_QMARK;
          end
        end
        P_QMARK: begin
          // empty query reads as absent
          if (c == ChSpace) begin
            adv.query_begin  = '0;
            adv.query_length = '0;
            adv.state        = P_VER;
          end else begin
            adv.query_begin = pos;
            adv.state       = P_QUERY;
          end
        end
        P_QUERY: begin
          if (c == ChSpace) begin
            adv.query_length = pos - ctx_q.query_begin;
            adv.state        = P_VER;
          end
        end
        P_VER: begin
          if (c != ver_char(ctx_q.ver_idx)) begin
            status = ST_BAD_VER;
          end else if (ctx_q.ver_idx == 3'd6) begin
            adv.ver_idx = 3'd0;
            adv.state   = P_VMINOR;
          end else begin
            adv.ver_idx = ctx_q.ver_idx + 3'd1;
          end
        end
        P_VMINOR: begin
          if (c != ChZero && c != ChOne) begin
            status = ST_BAD_VER;
          end else begin
            adv.ver_minor = c[0];
            adv.state     = P_VCR;
          end
        end
        P_VCR: begin
          if (c != ChCr) begin
            status = ST_BAD_VER;
          end else begin
            adv.state = P_VLF;
          end
        end
        P_VLF: begin
          if (c != ChLf) begin
            status = ST_BAD_VER;
          end else begin
            adv.state = H_START;
            status    = ST_LINE_DONE;
          end
        end
        H_START: begin
          if (c == ChCr) begin
            adv.state = H_END_LF;
          end else if (c == ChNul) begin
            status = ST_BAD_HDR;
          end else begin
            adv.name_begin = pos;
            adv.state      = H_NAME;
          end
        end
        H_NAME: begin
          if (c == ChNul || c == ChCr) begin
            status = ST_BAD_HDR;
          end else if (c == ChColon) begin
            adv.name_length = pos - ctx_q.name_begin;
            adv.state       = H_COLON;
          end
        end
        H_COLON: begin
          if (c != ChSpace) begin
            status = ST_BAD_HDR;
          end else begin
            adv.state = H_SP_VAL;
          end
        end
        H_SP_VAL: begin
          if (c == ChNul) begin
            status = ST_BAD_HDR;
          end else if (c == ChCr) begin
            adv.state = H_LF;
          end else if (c != ChSpace) begin
            adv.value_begin = pos;
            adv.state       = H_VALUE;
          end
        end
        H_VALUE: begin
          // length is taken at each space so trailing spaces drop out
          if (c == ChNul) begin
            status = ST_BAD_HDR;
          end else if (c == ChCr || c == ChSpace) begin
            adv.value_length = pos - ctx_q.value_begin;
            adv.state        = (c == ChSpace) ? H_SP_AFTER : H_LF;
          end
        end
        H_SP_AFTER: begin
          if (c == ChNul) begin
            status = ST_BAD_HDR;
          end else if (c == ChCr) begin
            adv.state = H_LF;
          end else if (c != ChSpace) begin
            adv.state = H_VALUE;
          end
        end
        H_LF: begin
          if (c != ChLf) begin
            status = ST_BAD_HDR;
          end else begin
            if (ctx_q.headers_seen != {CountW{1'b1}}) begin
              adv.headers_seen = ctx_q.headers_seen + CountW'(1);
            end
            adv.state = H_START;
            status    = ST_HDR_DONE;
          end
        end
        H_END_LF: begin
          if (c != ChLf) begin
            status = ST_BAD_HDR;
          end else begin
            status = ST_HEAD_DONE;
          end
        end
        default: begin
          status = ST_BAD_REQ;
        end
      endcase
      if (!is_error(status)) begin
        adv.offset = ctx_q.offset + OffW'(1);
      end
    end

    res_o.status        = status;
    res_o.method_kind   = adv.method_code;
    res_o.uri_start     = adv.uri_begin;
    res_o.uri_len       = adv.uri_length;
    res_o.query_start   = adv.query_begin;
    res_o.query_len     = adv.query_length;
    res_o.minor_version = adv.ver_minor;
    res_o.header_count  = adv.headers_seen;
    if (status == ST_HDR_DONE) begin
      res_o.name_start  = adv.name_begin;
      res_o.name_len    = adv.name_length;
      res_o.value_start = adv.value_begin;
      res_o.value_len   = adv.value_length;
    end else begin
      res_o.name_start  = '0;
      res_o.name_len    = '0;
      res_o.value_start = '0;
      res_o.value_len   = '0;
    end

    ctx_d = adv;
    if (status == ST_HDR_DONE) begin
      ctx_d.name_begin   = '0;
      ctx_d.name_length  = '0;
      ctx_d.value_begin  = '0;
      ctx_d.value_length = '0;
    end
    // a finished head starts the next request from scratch
    if (status == ST_HEAD_DONE) begin
      ctx_d = '0;
    end
    err_d = is_error(status) ? status : err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q <= '0;
      err_q <= ST_MORE;
    end else if (fire_i) begin
      ctx_q <= ctx_d;
      err_q <= err_d;
    end
  end

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ST_MORE) |=> (err_q == $past(err_q)))
    else $error("held error changed");

  a_err_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ST_MORE) |=> (ctx_q == $past(ctx_q)))
    else $error("parse state moved while an error is held");

  a_offset_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctx_q.offset <= OffW'(MaxHeadBytes))
    else $error("byte offset beyond head limit");

  a_ver_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctx_q.state != P_VER) |-> (ctx_q.ver_idx == 3'd0))
    else $error("version index left set outside version match");

  a_head_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.status == ST_HEAD_DONE) |=>
      (ctx_q.offset == '0 && ctx_q.state == P_START && ctx_q.headers_seen == '0))
    else $error("request not restarted after end of head");

endmodule

>>> rtl/core/hrhp_out_reg.sv
// ----------------------------------------------------------------------------
// hrhp_out_reg
// Result register: holds one parser result until the receiver takes it.
// ----------------------------------------------------------------------------
module hrhp_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  hrhp_pkg::hrhp_result_t res_i,
  output logic                   open_o,
  hrhp_result_if.source          res_o
);
  import hrhp_pkg::*;

  logic         valid_q;
  hrhp_result_t res_q;

  assign open_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (open_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (open_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.status        = res_q.status;
  assign res_o.method_kind   = res_q.method_kind;
  assign res_o.uri_start     = res_q.uri_start;
  assign res_o.uri_len       = res_q.uri_len;
  assign res_o.query_start   = res_q.query_start;
  assign res_o.query_len     = res_q.query_len;
  assign res_o.minor_version = res_q.minor_version;
  assign res_o.name_start    = res_q.name_start;
  assign res_o.name_len      = res_q.name_len;
  assign res_o.value_start   = res_q.value_start;
  assign res_o.value_len     = res_q.value_len;
  assign res_o.header_count  = res_q.header_count;

endmodule

>>> rtl/core/http_request_head_parser.sv
// ----------------------------------------------------------------------------
// http_request_head_parser
// Byte-wide HTTP/1.x request head parser with one result per input byte.
//
// req_i carries one byte of the request stream per request; res_o returns
// one result per byte: a status code, the method kind, URI and query
// offsets, the minor version, the header just completed (with status
// header done) and a saturating header count. Offsets count from the first
// byte of the current request and wrap at 4096.
// A taken byte waits in the input register; when it moves on it is parsed
// and its result is loaded into the result register and shown from then on.
// The parser sustains one byte per cycle while the receiver does not stall;
// the state update from the held byte is the loop that sets this rate.
// Reset clears the parse state, the held error and both pipeline registers.
// After a bad status every later byte returns the same status until reset;
// after the end of a head the next byte starts a new request at offset zero.
// When the receiver stalls the result register holds, the input register
// fills and then req_i.ready drops until the receiver takes a result.
// ----------------------------------------------------------------------------
module http_request_head_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  hrhp_byte_if.sink     req_i,
  hrhp_result_if.source res_o
);
  import hrhp_pkg::*;

  hrhp_in_t     in_s;
  hrhp_result_t res_s;
  logic         out_open;
  logic         fire;

  assign fire = in_s.valid && out_open;

  hrhp_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .take_i (fire),
    .in_o   (in_s)
  );

  hrhp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .data_byte_i (in_s.data_byte),
    .res_o       (res_s)
  );

  hrhp_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire),
    .res_i  (res_s),
    .open_o (out_open),
    .res_o  (res_o)
  );

endmodule

>>> tb/hrhp_checker.sv
// ----------------------------------------------------------------------------
// hrhp_checker
// Watches both channels of the request head parser, keeps its own copy of
// the parse state, predicts the result word of every byte taken and checks
// each result taken against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module hrhp_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  hrhp_byte_if   req_i,
  hrhp_result_if res_i,
  output int     fail_count_o,
  output int     pending_o,
  output int     checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import hrhp_pkg::*;

  typedef enum logic [4:0] {
    PS_START, PS_METHOD, PS_SP_URI, PS_URI, PS_QMARK, PS_QUERY, PS_VER,
    PS_VMINOR, PS_VCR, PS_VLF, HS_START, HS_NAME, HS_COLON, HS_SP_VAL,
    HS_VALUE, HS_SP_AFTER, HS_LF, HS_END_LF
  } parse_e;

  localparam logic [55:0] VerText  = "HTTP/1.";
  localparam int          MaxShown = 10;

  parse_e            pstate;
  logic [2:0]        ver_idx;
  status_e           held_err;
  int unsigned       head_off;
  logic [31:0]       meth_text;
  int unsigned       meth_len;
  method_e           meth_kind;
  logic [FieldW-1:0] uri_at, uri_n, qry_at, qry_n;
  logic [FieldW-1:0] name_at, name_n, val_at, val_n;
  logic              minor_digit;
  logic [CountW-1:0] hdr_cnt;
  hrhp_result_t      pending_results[$];
  int                shown;

  function automatic void clear_header();
    name_at = '0;
    name_n  = '0;
    val_at  = '0;
    val_n   = '0;
  endfunction

  function automatic void clear_request();
    pstate      = PS_START;
    ver_idx     = '0;
    head_off    = 0;
    meth_text   = '0;
    meth_len    = 0;
    meth_kind   = MK_NONE;
    uri_at      = '0;
    uri_n       = '0;
    qry_at      = '0;
    qry_n       = '0;
    minor_digit = 1'b0;
    hdr_cnt     = '0;
    clear_header();
  endfunction

  function automatic logic is_upper(logic [7:0] c);
    return (c >= ChUpA) && (c <= ChUpZ);
  endfunction

  // one byte through the state machine, pos is its offset in the request
  function automatic status_e step_parser(logic [7:0] c, logic [FieldW-1:0] pos);
    case (pstate)
      PS_START: begin
        if (c == ChCr || c == ChLf) return ST_MORE;
        if (!is_upper(c)) return ST_BAD_METHOD;
        meth_text = {24'h0, c};
        meth_len  = 1;
        pstate    = PS_METHOD;
      end
      PS_METHOD: begin
        if (c == ChSpace) begin
          if (meth_len == 3) begin
            if (meth_text != MethodGet) return ST_BAD_METHOD;
            meth_kind = MK_GET;
          end else if (meth_len == 4) begin
            if (meth_text != MethodPost) return ST_BAD_METHOD;
            meth_kind = MK_POST;
          end else begin
            meth_kind = MK_OTHER;
          end
          pstate = PS_SP_URI;
          return ST_MORE;
        end
        if (!is_upper(c)) return ST_BAD_METHOD;
        if (meth_len < 4) meth_text = {meth_text[23:0], c};
        if (meth_len < 7) meth_len++;
      end
      PS_SP_URI: begin
        if (c != ChSlash) return ST_BAD_REQ;
        uri_at = pos;
        pstate = PS_URI;
      end
      PS_URI: begin
        if (c == ChNul) return ST_BAD_URI;
        if (c == ChSpace || c == ChQmark) begin
          uri_n   = pos - uri_at;
          ver_idx = '0;
          pstate  = (c == ChSpace) ? PS_VER : PS_QMARK;
        end
      end
      PS_QMARK: begin
        if (c == ChSpace) begin
          qry_at  = '0;
          qry_n   = '0;
          ver_idx = '0;
          pstate  = PS_VER;
        end else begin
          qry_at = pos;
          pstate = PS_QUERY;
        end
      end
      PS_QUERY: begin
        if (c == ChSpace) begin
          qry_n   = pos - qry_at;
          ver_idx = '0;
          pstate  = PS_VER;
        end
      end
      PS_VER: begin
        if (c != VerText[55 - 8 * int'(ver_idx) -: 8]) return ST_BAD_VER;
        if (ver_idx == 3'd6) pstate = PS_VMINOR;
        else ver_idx++;
      end
      PS_VMINOR: begin
        if (c != ChZero && c != ChOne) return ST_BAD_VER;
        minor_digit = c[0];
        pstate      = PS_VCR;
      end
      PS_VCR: begin
        if (c != ChCr) return ST_BAD_VER;
        pstate = PS_VLF;
      end
      PS_VLF: begin
        if (c != ChLf) return ST_BAD_VER;
        pstate = HS_START;
        return ST_LINE_DONE;
      end
      HS_START: begin
        if (c == ChCr) begin
          pstate = HS_END_LF;
          return ST_MORE;
        end
        if (c == ChNul) return ST_BAD_HDR;
        name_at = pos;
        pstate  = HS_NAME;
      end
      HS_NAME: begin
        if (c == ChNul || c == ChCr) return ST_BAD_HDR;
        if (c == ChColon) begin
          name_n = pos - name_at;
          pstate = HS_COLON;
        end
      end
      HS_COLON: begin
        if (c != ChSpace) return ST_BAD_HDR;
        pstate = HS_SP_VAL;
      end
      HS_SP_VAL: begin
        if (c == ChNul) return ST_BAD_HDR;
        if (c == ChCr) begin
          pstate = HS_LF;
        end else if (c != ChSpace) begin
          val_at = pos;
          pstate = HS_VALUE;
        end
      end
      HS_VALUE: begin
        if (c == ChNul) return ST_BAD_HDR;
        // length is taken at every space so trailing blanks drop out
        if (c == ChCr || c == ChSpace) begin
          val_n  = pos - val_at;
          pstate = (c == ChSpace) ? HS_SP_AFTER : HS_LF;
        end
      end
      HS_SP_AFTER: begin
        if (c == ChNul) return ST_BAD_HDR;
        if (c == ChCr) pstate = HS_LF;
        else if (c != ChSpace) pstate = HS_VALUE;
      end
      HS_LF: begin
        if (c != ChLf) return ST_BAD_HDR;
        if (hdr_cnt != '1) hdr_cnt++;
        pstate = HS_START;
        return ST_HDR_DONE;
      end
      HS_END_LF: begin
        if (c != ChLf) return ST_BAD_HDR;
        return ST_HEAD_DONE;
      end
      default: return ST_BAD_REQ;
    endcase
    return ST_MORE;
  endfunction

  function automatic hrhp_result_t predict_result(logic [7:0] c);
    hrhp_result_t r;
    status_e      st;
    if (held_err != ST_MORE) begin
      st = held_err;
    end else if (head_off >= MaxHeadBytes) begin
      st = ST_BAD_REQ;
    end else begin
      st = step_parser(c, head_off[FieldW-1:0]);
      if (st < ST_BAD_METHOD) head_off++;
    end
    if (st >= ST_BAD_METHOD) held_err = st;

    r               = '0;
    r.status        = st;
    r.method_kind   = meth_kind;
    r.uri_start     = uri_at;
    r.uri_len       = uri_n;
    r.query_start   = qry_at;
    r.query_len     = qry_n;
    r.minor_version = minor_digit;
    if (st == ST_HDR_DONE) begin
      r.name_start  = name_at;
      r.name_len    = name_n;
      r.value_start = val_at;
      r.value_len   = val_n;
      clear_header();
    end
    r.header_count = hdr_cnt;
    // end of head: the next byte opens a new request at offset zero
    if (st == ST_HEAD_DONE) clear_request();
    return r;
  endfunction

  function automatic int field_diff(string field, int unsigned want_v,
                                    int unsigned got_v, bit show);
    if (want_v == got_v) return 0;
    if (show) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    end
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hrhp_result_t want, got;
    int           bad;
    bit           show;
    if (!rst_ni) begin
      held_err = ST_MORE;
      clear_request();
      pending_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      shown        = 0;
    end else begin
      show = (shown < MaxShown);
      if (res_i.valid && res_i.ready) begin
        got.status        = res_i.status;
        got.method_kind   = res_i.method_kind;
        got.uri_start     = res_i.uri_start;
        got.uri_len       = res_i.uri_len;
        got.query_start   = res_i.query_start;
        got.query_len     = res_i.query_len;
        got.minor_version = res_i.minor_version;
        got.name_start    = res_i.name_start;
        got.name_len      = res_i.name_len;
        got.value_start   = res_i.value_start;
        got.value_len     = res_i.value_len;
        got.header_count  = res_i.header_count;
        if (pending_results.size() == 0) begin
          fail_count_o++;
          if (show) begin
            $display("%0t: result with no byte waiting, expected none, actual status %0d",
                     $time, got.status);
          end
          shown++;
        end else begin
          want = pending_results.pop_front();
          bad  = field_diff("status", want.status, got.status, show)
               + field_diff("method_kind", want.method_kind, got.method_kind, show)
               + field_diff("uri_start", want.uri_start, got.uri_start, show)
               + field_diff("uri_len", want.uri_len, got.uri_len, show)
               + field_diff("query_start", want.query_start, got.query_start, show)
               + field_diff("query_len", want.query_len, got.query_len, show)
               + field_diff("minor_version", want.minor_version, got.minor_version, show)
               + field_diff("name_start", want.name_start, got.name_start, show)
               + field_diff("name_len", want.name_len, got.name_len, show)
               + field_diff("value_start", want.value_start, got.value_start, show)
               + field_diff("value_len", want.value_len, got.value_len, show)
               + field_diff("header_count", want.header_count, got.header_count, show);
          if (bad != 0) begin
            fail_count_o++;
            shown++;
          end
          checked_o++;
        end
      end
      if (req_i.valid && req_i.ready) begin
        pending_results.push_back(predict_result(req_i.data_byte));
      end
      pending_o = pending_results.size();
    end
  end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams of HTTP request heads into the parser: a short fixed
// head, random well-formed heads (one at or past the header count limit) and a
// closing malformed or oversized head whose error must hold. Both sides
// stall at random; the receiver also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hrhp_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomBytes = 650;
  localparam int unsigned IdlePct     = 31;
  localparam int unsigned HoldAfter   = 100;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        idle_on = 1'b1;
  int          fail_count, pending, checked;
  int unsigned cycle_cnt;
  int unsigned bytes_sent;
  int unsigned heads_sent;
  logic [7:0]  head_bytes[$];
  string       tail_name;

  hrhp_byte_if   req ();
  hrhp_result_if res ();

  http_request_head_parser u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res)
  );

  hrhp_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .res_i        (res),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus one long hold-off once traffic is flowing
  initial begin
    int unsigned hold_left;
    int unsigned taken;
    bit          held_once;
    hold_left = 0;
    taken     = 0;
    held_once = 1'b0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res.valid && res.ready) taken++;
      if (!held_once && taken >= HoldAfter) begin
        hold_left = HoldCycles;
        held_once = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= !(idle_on && $urandom_range(99) < IdlePct);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("run timed out after %0d cycles", cycle_cnt);
    $display("== FAIL ==");
    $finish;
  end

  task automatic push_byte(logic [7:0] b);
    while (idle_on && $urandom_range(99) < IdlePct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid     <= 1'b1;
    req.data_byte <= b;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_bytes();
    foreach (head_bytes[i]) push_byte(head_bytes[i]);
    head_bytes.delete();
  endtask

  function automatic logic [7:0] pick_upper();
    return ChUpA + 8'($urandom_range(25));
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) head_bytes.push_back(s[i]);
  endfunction

  function automatic void add_crlf();
    head_bytes.push_back(ChCr);
    head_bytes.push_back(ChLf);
  endfunction

  function automatic void add_request_line();
    int unsigned lead, len, pick;
    logic [7:0]  b;
    lead = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (lead) head_bytes.push_back($urandom_range(1) ? ChCr : ChLf);
    pick = $urandom_range(9);
    if (pick < 4) begin
      add_text("GET");
    end else if (pick < 7) begin
      add_text("POST");
    end else begin
      // other methods skip the lengths that must be GET or POST
      len = $urandom_range(1, 7);
      if (len >= 3) len += 2;
      repeat (len) head_bytes.push_back(pick_upper());
    end
    head_bytes.push_back(ChSpace);
    head_bytes.push_back(ChSlash);
    len = ($urandom_range(9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 6);
    repeat (len) begin
      do b = 8'($urandom_range(1, 255)); while (b == ChSpace || b == ChQmark);
      head_bytes.push_back(b);
    end
    pick = $urandom_range(2);
    if (pick != 0) begin
      head_bytes.push_back(ChQmark);
      if (pick == 2) begin
        repeat ($urandom_range(1, 8)) begin
          do b = 8'($urandom_range(255)); while (b == ChSpace);
          head_bytes.push_back(b);
        end
      end
    end
    add_text(" HTTP/1.");
    head_bytes.push_back($urandom_range(1) ? ChOne : ChZero);
    add_crlf();
  endfunction

  function automatic void add_name(int unsigned max_txt);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == ChNul || b == ChCr);
    head_bytes.push_back(b);
    repeat ($urandom_range(0, max_txt - 1)) begin
      do b = 8'($urandom_range(255)); while (b == ChNul || b == ChCr || b == ChColon);
      head_bytes.push_back(b);
    end
  endfunction

  function automatic void add_header(int unsigned max_txt);
    logic [7:0] b;
    add_name(max_txt);
    head_bytes.push_back(ChColon);
    head_bytes.push_back(ChSpace);
    repeat ($urandom_range(2)) head_bytes.push_back(ChSpace);
    repeat ($urandom_range(0, max_txt)) begin
      if ($urandom_range(5) == 0) begin
        b = ChSpace;
      end else begin
        do b = 8'($urandom_range(255)); while (b == ChNul || b == ChCr);
      end
      head_bytes.push_back(b);
    end
    repeat ($urandom_range(2)) head_bytes.push_back(ChSpace);
    add_crlf();
  endfunction

  function automatic void add_request(int unsigned n_hdr, int unsigned max_txt);
    add_request_line();
    repeat (n_hdr) add_header(max_txt);
    add_crlf();
  endfunction

  // last request of the run: the error it raises holds until reset
  function automatic void add_error_tail();
    int unsigned kind, sub, len, p;
    logic [7:0]  b;
    logic [31:0] w;
    logic [7:0]  letters[4];
    logic [7:0]  good[10];
    good = '{ChUpH, ChUpT, ChUpT, ChUpP, ChSlash, ChOne, ChDot, ChOne, ChCr, ChLf};
    kind = $urandom_range(7);
    case (kind)
      0: begin
        tail_name = "non-letter first method byte";
        if ($urandom_range(1)) head_bytes.push_back(ChLf);
        do b = 8'($urandom_range(255));
        while ((b >= ChUpA && b <= ChUpZ) || b == ChCr || b == ChLf);
        head_bytes.push_back(b);
      end
      1: begin
        tail_name = "three or four letter method other than GET or POST";
        len = $urandom_range(3, 4);
        do begin
          w = '0;
          for (int i = 0; i < len; i++) begin
            letters[i] = pick_upper();
            w = {w[23:0], letters[i]};
          end
        end while (w == MethodGet || w == MethodPost);
        for (int i = 0; i < len; i++) head_bytes.push_back(letters[i]);
        head_bytes.push_back(ChSpace);
      end
      2: begin
        tail_name = "non-letter inside the method";
        repeat ($urandom_range(1, 5)) head_bytes.push_back(pick_upper());
        do b = 8'($urandom_range(255));
        while ((b >= ChUpA && b <= ChUpZ) || b == ChSpace);
        head_bytes.push_back(b);
      end
      3: begin
        tail_name = "uri without leading slash";
        add_text("GET ");
        do b = 8'($urandom_range(255)); while (b == ChSlash);
        head_bytes.push_back(b);
      end
      4: begin
        tail_name = "nul byte in uri path";
        add_text("GET /");
        repeat ($urandom_range(5)) head_bytes.push_back(pick_upper());
        head_bytes.push_back(ChNul);
      end
      5: begin
        tail_name = "broken version text";
        add_text("POST / ");
        p = $urandom_range(9);
        for (int i = 0; i < p; i++) head_bytes.push_back(good[i]);
        do b = 8'($urandom_range(255)); while (b == good[p] || (p == 7 && b == ChZero));
        head_bytes.push_back(b);
      end
      6: begin
        tail_name = "malformed header line";
        add_request_line();
        repeat ($urandom_range(2)) add_header(4);
        sub = $urandom_range(8);
        case (sub)
          0: head_bytes.push_back(ChNul);
          1: begin
            add_name(4);
            head_bytes.push_back(ChNul);
          end
          2: begin
            // line ends before any colon
            add_name(4);
            head_bytes.push_back(ChCr);
          end
          3: begin
            add_name(4);
            head_bytes.push_back(ChColon);
            do b = 8'($urandom_range(255)); while (b == ChSpace);
            head_bytes.push_back(b);
          end
          4: begin
            add_name(4);
            add_text(": ");
            head_bytes.push_back(ChNul);
          end
          5: begin
            add_name(4);
            add_text(": ");
            head_bytes.push_back(pick_upper());
            head_bytes.push_back(ChNul);
          end
          6: begin
            add_name(4);
            add_text(": ");
            head_bytes.push_back(pick_upper());
            head_bytes.push_back(ChSpace);
            head_bytes.push_back(ChNul);
          end
          7: begin
            add_name(4);
            add_text(": ");
            head_bytes.push_back(pick_upper());
            head_bytes.push_back(ChCr);
            do b = 8'($urandom_range(255)); while (b == ChLf);
            head_bytes.push_back(b);
          end
          default: begin
            head_bytes.push_back(ChCr);
            do b = 8'($urandom_range(255)); while (b == ChLf);
            head_bytes.push_back(b);
          end
        endcase
      end
      default: begin
        tail_name = "head longer than the byte limit";
        add_request_line();
        while (head_bytes.size() < MaxHeadBytes + 4) add_header(12);
      end
    endcase
    repeat (4) head_bytes.push_back(8'($urandom_range(255)));
  endfunction

  initial begin
    int unsigned random_bytes, n;
    rst_ni        <= 1'b0;
    req.valid     <= 1'b0;
    req.data_byte <= 8'h00;
    bytes_sent    = 0;
    heads_sent    = 0;
    random_bytes  = 0;
    n             = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // skipped line breaks, GET with an empty query, one header with no value
    add_crlf();
    add_text("GET /? HTTP/1.0");
    add_crlf();
    add_text("A: ");
    add_crlf();
    add_crlf();
    send_bytes();
    heads_sent++;

    while (random_bytes < RandomBytes) begin
      idle_on = !(n >= 4 && n < 8);
      if (n == 3) begin
        // enough short headers to saturate the header count
        add_request($urandom_range(255, 262), 1);
      end else begin
        add_request($urandom_range(0, 4), 6);
        random_bytes += head_bytes.size();
      end
      send_bytes();
      heads_sent++;
      n++;
    end
    idle_on = 1'b1;

    add_error_tail();
    send_bytes();
    // last byte is in, stop offering
    req.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("checked %0d results over %0d bytes, %0d complete heads",
             checked, bytes_sent, heads_sent);
    $display("incl. one at the header count limit; closing case: %s, then bytes under the held error",
             tail_name);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/hrhp_pkg.sv
rtl/core/hrhp_byte_if.sv
rtl/core/hrhp_result_if.sv
rtl/core/hrhp_in_reg.sv
rtl/core/hrhp_parser.sv
rtl/core/hrhp_out_reg.sv
rtl/core/http_request_head_parser.sv
tb/hrhp_checker.sv
tb/testbench.sv
